### src/grayscale_window_min_max_filter_unit_macros.svh
// Assertion macros for the window min/max filter
`ifndef GRAYSCALE_WINDOW_MIN_MAX_FILTER_UNIT_MACROS_SVH
`define GRAYSCALE_WINDOW_MIN_MAX_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define GWMM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define GWMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GWMM_ASSERT(lbl, cond, msg)
`define GWMM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### src/gwmm_pkg.sv
// Shared types, constants and helpers of the window min/max filter
`default_nettype none
package gwmm_pkg;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 3;
  localparam int PIX_W          = 8;
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int RADIUS_W       = 2;
  localparam int MODE_W         = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 2'd1;
  localparam logic [CFG_W-1:0]    WIDTH_RESET  = 11'd1024;

  localparam logic [MODE_W-1:0] MODE_EROSION  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DILATION = 2'd1;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t pix;
    logic   last_run;
    logic   last_frame;
  } result_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } col_ctrl_t;

  function automatic pixel_t pmin(pixel_t a, pixel_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pixel_t pmax(pixel_t a, pixel_t b);
    return (a > b) ? a : b;
  endfunction
endpackage
`default_nettype wire

### src/grayscale_window_min_max_filter_unit.sv
// An accepted item passes the stage 1 and stage 2 registers before its results enter the output
// queue, whose head drives the output port. Throughput: one item per cycle, set by the single line
// store port pair; an item ending a row pushes up to R+1 results at once, drained one per cycle
// while the output is ready, and input stalls while the queue lacks room for a full burst plus items in flight.
// Reset clears counters, pipeline and queue; the line store is not cleared (rows are masked).
`default_nettype none
`include "grayscale_window_min_max_filter_unit_macros.svh"
module grayscale_window_min_max_filter_unit #(
  parameter int MAX_WIDTH  = gwmm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = gwmm_pkg::MAX_RADIUS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] pixel
  input  logic                           s_axis_tuser,  // [0] drain
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [7:0] out_pixel
  output logic                           m_axis_tuser,  // [0] last_in_run
  output logic                           m_axis_tlast,
  input  logic                           cfg_we,
  input  logic [gwmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gwmm_pkg::CFG_W-1:0]     cfg_data
);
  localparam int PW    = gwmm_pkg::PIX_W;
  localparam int LINES = 2 * MAX_RADIUS;
  localparam int NRES  = MAX_RADIUS + 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int SW    = $clog2(LINES + 1);
  localparam int DW    = $clog2(MAX_RADIUS * MAX_WIDTH + 1);
  localparam int NW    = $clog2(NRES + 1);
  localparam int FD    = 2 ** $clog2(4 * NRES);
  localparam int FAW   = $clog2(FD);
  localparam int LSW   = LINES * PW;

  // configuration
  logic [gwmm_pkg::RADIUS_W-1:0] window_radius;
  logic [gwmm_pkg::MODE_W-1:0]   mode;
  logic [gwmm_pkg::CFG_W-1:0]    line_width;
  logic                          geo_write;

  logic [RW-1:0] eff_r;
  logic [WW-1:0] eff_w;
  logic [DW-1:0] drain_limit;

  // frame counters
  logic [CW-1:0] column_count;
  logic [SW-1:0] rows_seen;
  logic [DW-1:0] drain_count;

  // input stage
  logic             in_acc;
  logic             drain;
  logic             skip;
  gwmm_pkg::pixel_t px0;
  logic [CW-1:0]    c0;
  logic             rows_ok;
  logic             main_hit;
  logic             row_end;
  logic [RW-1:0]    first0;
  logic [NW-1:0]    cnt0;
  logic             frame_end0;
  logic             wrap0;

  // stage 1: line store data back
  logic             s1_valid;
  gwmm_pkg::pixel_t s1_px;
  logic [CW-1:0]    s1_c;
  logic [SW-1:0]    s1_rows;
  logic             s1_clear;
  logic [RW-1:0]    s1_first;
  logic [NW-1:0]    s1_cnt;
  logic             s1_fend;
  logic             s1_fwd;
  logic [LSW-1:0]   s1_fwd_word;
  logic [LSW-1:0]   ls_rd_data;
  logic [LSW-1:0]   rd_word;
  logic [LSW-1:0]   wr_word;
  gwmm_pkg::pixel_t col_min;
  gwmm_pkg::pixel_t col_max;
  gwmm_pkg::col_ctrl_t win_ctrl;

  // stage 2: window complete
  logic             s2_valid;
  logic [RW-1:0]    s2_first;
  logic [NW-1:0]    s2_cnt;
  logic             s2_fend;
  gwmm_pkg::pixel_t [MAX_RADIUS:0] slot;
  gwmm_pkg::result_t res [NRES];

  // output queue
  gwmm_pkg::result_t fifo_mem [FD];
  logic [FAW-1:0]    wr_ptr;
  logic [FAW-1:0]    rd_ptr;
  logic [FAW:0]      fifo_count;
  logic [NW-1:0]     push_n;
  logic              pop;
  logic [FAW+1:0]    committed;
  gwmm_pkg::result_t head;

  assign geo_write = cfg_we &&
                     (cfg_index == gwmm_pkg::REG_RADIUS || cfg_index == gwmm_pkg::REG_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_radius <= gwmm_pkg::RADIUS_RESET;
      mode          <= gwmm_pkg::MODE_EROSION;
      line_width    <= gwmm_pkg::WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gwmm_pkg::REG_RADIUS: window_radius <= cfg_data[gwmm_pkg::RADIUS_W-1:0];
        gwmm_pkg::REG_MODE:   mode          <= cfg_data[gwmm_pkg::MODE_W-1:0];
        gwmm_pkg::REG_WIDTH:  line_width    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(window_radius) > MAX_RADIUS) begin
      eff_r = RW'(MAX_RADIUS);
    end else begin
      eff_r = RW'(window_radius);
    end
    if (line_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(line_width) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(line_width);
    end
    drain_limit = DW'(32'(eff_r) * 32'(eff_w));
  end

  // input stage decode
  always_comb begin
    in_acc     = s_axis_tvalid && s_axis_tready;
    drain      = s_axis_tuser;
    skip       = drain && (eff_r == '0);
    px0        = drain ? '0 : s_axis_tdata;
    c0         = (WW'(column_count) >= eff_w) ? '0 : column_count;
    rows_ok    = 32'(rows_seen) >= 32'(eff_r);
    main_hit   = 32'(c0) >= 32'(eff_r);
    row_end    = WW'(c0) == (eff_w - WW'(1));
    first0     = main_hit ? '0 : RW'(int'(eff_r) - int'(c0));
    wrap0      = (WW'(c0) + WW'(1)) >= eff_w;
    frame_end0 = drain && (({1'b0, drain_count} + (DW+1)'(1)) >= {1'b0, drain_limit});
    if (!rows_ok) begin
      cnt0 = '0;
    end else if (row_end) begin
      cnt0 = NW'(int'(eff_r) + 1 - int'(first0));
    end else begin
      cnt0 = main_hit ? NW'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || geo_write) begin
      column_count <= '0;
      rows_seen    <= '0;
      drain_count  <= '0;
    end else if (in_acc) begin
      if (skip) begin
        column_count <= '0;
        rows_seen    <= '0;
        drain_count  <= '0;
      end else if (drain && frame_end0) begin
        column_count <= '0;
        rows_seen    <= '0;
        drain_count  <= '0;
      end else begin
        if (wrap0) begin
          column_count <= '0;
          if (32'(rows_seen) < 32'(LINES)) begin
            rows_seen <= rows_seen + SW'(1);
          end
        end else begin
          column_count <= c0 + CW'(1);
        end
        drain_count <= drain ? (drain_count + DW'(1)) : '0;
      end
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc && !skip;
    end
  end

  always_ff @(posedge clk) begin
    s1_px       <= px0;
    s1_c        <= c0;
    s1_rows     <= rows_seen;
    s1_clear    <= (c0 == '0);
    s1_first    <= first0;
    s1_cnt      <= cnt0;
    s1_fend     <= frame_end0;
    // the item ahead writes the same column this cycle: take its word
    s1_fwd      <= s1_valid && (s1_c == c0);
    s1_fwd_word <= wr_word;
  end

  gwmm_line_store #(
    .DEPTH (MAX_WIDTH),
    .WORD_W(LSW),
    .AW    (CW)
  ) u_lines (
    .clk    (clk),
    .wr_en  (s1_valid),
    .wr_addr(s1_c),
    .wr_data(wr_word),
    .rd_addr(c0),
    .rd_data(ls_rd_data)
  );

  assign rd_word = s1_fwd ? s1_fwd_word : ls_rd_data;
  // advance every line by one row, newest pixel into line 0
  assign wr_word = {rd_word[LSW-PW-1:0], s1_px};

  always_comb begin
    gwmm_pkg::pixel_t v;
    col_min = s1_px;
    col_max = s1_px;
    for (int j = 0; j < LINES; j++) begin
      v = (int'(s1_rows) > j) ? rd_word[j*PW +: PW] : '0;
      if (j < 2 * int'(eff_r)) begin
        col_min = gwmm_pkg::pmin(col_min, v);
        col_max = gwmm_pkg::pmax(col_max, v);
      end
    end
  end

  assign win_ctrl = '{shift: s1_valid, clear: s1_clear};

  gwmm_window #(
    .MAX_RADIUS(MAX_RADIUS),
    .RW        (RW)
  ) u_window (
    .clk    (clk),
    .ctrl   (win_ctrl),
    .col_min(col_min),
    .col_max(col_max),
    .radius (eff_r),
    .mode   (mode),
    .slot   (slot)
  );

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_first <= s1_first;
    s2_cnt   <= s1_cnt;
    s2_fend  <= s1_fend;
  end

  always_comb begin
    int idx;
    logic [RW-1:0] sidx;
    for (int i = 0; i < NRES; i++) begin
      idx  = int'(s2_first) + i;
      sidx = RW'(idx);
      res[i].pix        = (idx <= MAX_RADIUS) ? slot[sidx] : '0;
      res[i].last_run   = (i == int'(s2_cnt) - 1);
      res[i].last_frame = (i == int'(s2_cnt) - 1) && s2_fend;
    end
  end

  // output queue: a burst of results lands together, in the same cycle
  assign push_n = s2_valid ? s2_cnt : '0;
  assign pop    = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    for (int i = 0; i < NRES; i++) begin
      if (s2_valid && i < int'(s2_cnt)) begin
        fifo_mem[wr_ptr + FAW'(i)] <= res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + FAW'(push_n);
      rd_ptr     <= rd_ptr + FAW'(pop);
      fifo_count <= fifo_count + (FAW+1)'(push_n) - (FAW+1)'(pop);
    end
  end

  // hold input while queue plus in-flight results could not take one more burst
  always_comb begin
    committed = (FAW+2)'(fifo_count)
              + (s1_valid ? (FAW+2)'(s1_cnt) : '0)
              + (s2_valid ? (FAW+2)'(s2_cnt) : '0);
    s_axis_tready = committed <= (FAW+2)'(FD - NRES);
  end

  assign head          = fifo_mem[rd_ptr];
  assign m_axis_tvalid = fifo_count != '0;
  assign m_axis_tdata  = head.pix;
  assign m_axis_tuser  = head.last_run;
  assign m_axis_tlast  = head.last_frame;

  `GWMM_ASSERT(a_fifo_bound, fifo_count <= (FAW+1)'(FD), "output queue count out of range")
  `GWMM_ASSERT(a_push_fits, !s2_valid || (32'(fifo_count) + 32'(s2_cnt) <= FD), "queue overrun")
  `GWMM_ASSERT_NEXT(a_s1_follows, in_acc && !skip, s1_valid, "accepted item lost before stage 1")
  `GWMM_ASSERT_NEXT(a_s2_follows, s1_valid, s2_valid, "item lost between stages")
  `GWMM_ASSERT(a_clear_at_row, !(s1_valid && s1_clear) || s1_c == '0, "window cleared mid-row")
endmodule
`default_nettype wire

### src/gwmm_line_store.sv
// Line buffer memory: one word holds a column of all stored rows
`default_nettype none
module gwmm_line_store #(
  parameter int DEPTH  = gwmm_pkg::MAX_WIDTH_DEF,
  parameter int WORD_W = 2 * gwmm_pkg::MAX_RADIUS_DEF * gwmm_pkg::PIX_W,
  parameter int AW     = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data
);
  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

### src/gwmm_cell.sv
// One window column: holds the column minimum and maximum
`default_nettype none
module gwmm_cell (
  input  logic                clk,
  input  gwmm_pkg::col_ctrl_t ctrl,
  input  gwmm_pkg::pixel_t    in_min,
  input  gwmm_pkg::pixel_t    in_max,
  output gwmm_pkg::pixel_t    out_min,
  output gwmm_pkg::pixel_t    out_max
);
  gwmm_pkg::pixel_t cmin;
  gwmm_pkg::pixel_t cmax;

  // a new row starts with zero columns behind the first one
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      if (ctrl.clear) begin
        cmin <= '0;
        cmax <= '0;
      end else begin
        cmin <= in_min;
        cmax <= in_max;
      end
    end
  end

  assign out_min = cmin;
  assign out_max = cmax;
endmodule
`default_nettype wire

### src/gwmm_window.sv
// Row of column cells and the window reduction into result slots
`default_nettype none
module gwmm_window #(
  parameter int MAX_RADIUS = gwmm_pkg::MAX_RADIUS_DEF,
  parameter int RW         = $clog2(MAX_RADIUS + 1)
) (
  input  logic                                 clk,
  input  gwmm_pkg::col_ctrl_t                  ctrl,
  input  gwmm_pkg::pixel_t                     col_min,
  input  gwmm_pkg::pixel_t                     col_max,
  input  logic [RW-1:0]                        radius,
  input  logic [gwmm_pkg::MODE_W-1:0]          mode,
  output gwmm_pkg::pixel_t [MAX_RADIUS:0]      slot
);
  localparam int SPAN = 2 * MAX_RADIUS + 1;
  localparam int IW   = $clog2(SPAN);

  gwmm_pkg::pixel_t  cmin [SPAN];
  gwmm_pkg::pixel_t  cmax [SPAN];
  gwmm_pkg::pixel_t  pre  [SPAN];
  gwmm_pkg::pixel_t  full_min;
  gwmm_pkg::col_ctrl_t head_ctrl;
  logic [IW-1:0]     top_idx;

  // the head always takes the new column, even on a row start
  assign head_ctrl = '{shift: ctrl.shift, clear: 1'b0};
  assign top_idx   = IW'(2 * int'(radius));

  gwmm_cell u_head (
    .clk    (clk),
    .ctrl   (head_ctrl),
    .in_min (col_min),
    .in_max (col_max),
    .out_min(cmin[0]),
    .out_max(cmax[0])
  );

  for (genvar i = 1; i < SPAN; i++) begin : g_cell
    gwmm_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .in_min (cmin[i-1]),
      .in_max (cmax[i-1]),
      .out_min(cmin[i]),
      .out_max(cmax[i])
    );
  end

  always_comb begin
    full_min = '1;
    pre[0]   = cmax[0];
    for (int i = 0; i < SPAN; i++) begin
      if (i <= 2 * int'(radius)) begin
        full_min = gwmm_pkg::pmin(full_min, cmin[i]);
      end
      if (i > 0) begin
        pre[i] = gwmm_pkg::pmax(pre[i-1], cmax[i]);
      end
    end
  end

  // past the row end, zero columns enter: minimum is zero, maximum
  // covers the remaining real columns only
  always_comb begin
    unique case (mode)
      gwmm_pkg::MODE_EROSION:  slot[0] = full_min;
      gwmm_pkg::MODE_DILATION: slot[0] = pre[top_idx];
      default:                 slot[0] = '0;
    endcase
    for (int k = 1; k <= MAX_RADIUS; k++) begin
      if (mode == gwmm_pkg::MODE_DILATION && k <= int'(radius)) begin
        slot[k] = pre[top_idx - IW'(k)];
      end else begin
        slot[k] = '0;
      end
    end
  end
endmodule
`default_nettype wire
